// ----- rtl/core/bole_pkg.sv -----
// Shared types and codes for the bounded ordered list engine.
// Holds the request and response structs, operation and status codes.
// No dependencies.
package bole_pkg;

   localparam int DEPTH_DEF      = 64;
   localparam int DATA_WIDTH_DEF = 32;

   // Operation codes carried in the request.
   localparam logic [2:0] MODE_PUSH_FRONT = 3'd0;
   localparam logic [2:0] MODE_PUSH_BACK  = 3'd1;
   localparam logic [2:0] MODE_POP_FRONT  = 3'd2;
   localparam logic [2:0] MODE_POP_BACK   = 3'd3;
   localparam logic [2:0] MODE_REMOVE     = 3'd4;
   localparam logic [2:0] MODE_CLEAR      = 3'd5;

   // Status codes returned with every response.
   localparam logic [1:0] STATUS_DONE      = 2'd0;
   localparam logic [1:0] STATUS_EMPTY     = 2'd1;
   localparam logic [1:0] STATUS_FULL      = 2'd2;
   localparam logic [1:0] STATUS_NOT_FOUND = 2'd3;

   typedef struct packed {
      logic [2:0]  mode;
      logic [31:0] value;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [6:0]  count;
      logic [31:0] front_value;
      logic [31:0] back_value;
      logic        is_empty;
   } rsp_type;

endpackage

// ----- rtl/core/bole_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module bole_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/bole_ctrl.sv -----
// Sequencer and datapath of the bounded ordered list engine.
// Drives the element RAM, forming store positions with slot_of and matching keys with one comparator.
// Depends on bole_pkg.
module bole_ctrl #(
   parameter int DEPTH      = bole_pkg::DEPTH_DEF,
   parameter int DATA_WIDTH = bole_pkg::DATA_WIDTH_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  bole_pkg::req_type        req_data,
   output logic                     busy,
   output logic                     rsp_strobe,
   output bole_pkg::rsp_type        rsp_data,
   output logic                     ram_we,
   output logic [$clog2(DEPTH)-1:0] ram_waddr,
   output logic [DATA_WIDTH-1:0]    ram_wdata,
   output logic [$clog2(DEPTH)-1:0] ram_raddr,
   input  logic [DATA_WIDTH-1:0]    ram_rdata
);

   import bole_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int SW = AW + 2;
   localparam logic [SW-1:0] DEPTH_S = SW'(DEPTH);
   localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
   localparam logic [AW-1:0] LAST_A  = AW'(DEPTH - 1);

   typedef enum logic [5:0] {
      ST_IDLE     = 6'b000001,
      ST_SCAN     = 6'b000010,
      ST_SHIFT    = 6'b000100,
      ST_RD_FRONT = 6'b001000,
      ST_RD_BACK  = 6'b010000,
      ST_FINISH   = 6'b100000
   } state_type;

   // Store position of the k-th element counted from the front.
   function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] base,
                                             input logic [SW-1:0] k);
      logic [SW-1:0] sum;
      sum = SW'(base) + k;
      if (sum >= DEPTH_S) begin
         sum = sum - DEPTH_S;
      end
      if (sum >= DEPTH_S) begin
         sum = sum - DEPTH_S;
      end
      return sum[AW-1:0];
   endfunction

   state_type             state_ff, state_in;
   logic [AW-1:0]         head_ff, head_in;
   logic [CW-1:0]         count_ff, count_in;
   logic [CW-1:0]         idx_ff, idx_in;
   logic [DATA_WIDTH-1:0] key_ff, key_in;
   logic [DATA_WIDTH-1:0] front_ff, front_in;
   logic [1:0]            status_ff, status_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_ff, rsp_in;

   logic [DATA_WIDTH-1:0] req_value;
   logic [SW-1:0]         idx_next;
   logic [SW-1:0]         idx_ahead;
   logic [SW-1:0]         count_s;
   logic                  key_match;
   logic [AW-1:0]         head_prev;

   assign req_value = DATA_WIDTH'(req_data.value);
   assign idx_next  = SW'(idx_ff) + SW'(1);
   assign idx_ahead = SW'(idx_ff) + SW'(2);
   assign count_s   = SW'(count_ff);
   assign key_match = (ram_rdata == key_ff);
   assign head_prev = (head_ff == '0) ? LAST_A : head_ff - 1'b1;

   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      key_in       = key_ff;
      front_in     = front_ff;
      status_in    = status_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      ram_we       = 1'b0;
      ram_waddr    = head_ff;
      ram_wdata    = req_value;
      ram_raddr    = head_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               status_in = STATUS_DONE;
               key_in    = req_value;
               idx_in    = '0;
               case (req_data.mode)
                  MODE_PUSH_FRONT: begin
                     if (count_ff == DEPTH_C) begin
                        status_in = STATUS_FULL;
                     end else begin
                        ram_we    = 1'b1;
                        ram_waddr = head_prev;
                        head_in   = head_prev;
                        count_in  = count_ff + 1'b1;
                     end
                  end
                  MODE_PUSH_BACK: begin
                     if (count_ff == DEPTH_C) begin
                        status_in = STATUS_FULL;
                     end else begin
                        ram_we    = 1'b1;
                        ram_waddr = slot_of(head_ff, count_s);
                        count_in  = count_ff + 1'b1;
                     end
                  end
                  MODE_POP_FRONT: begin
                     if (count_ff == '0) begin
                        status_in = STATUS_EMPTY;
                     end else begin
                        head_in  = slot_of(head_ff, SW'(1));
                        count_in = count_ff - 1'b1;
                     end
                  end
                  MODE_POP_BACK: begin
                     if (count_ff == '0) begin
                        status_in = STATUS_EMPTY;
                     end else begin
                        count_in = count_ff - 1'b1;
                     end
                  end
                  MODE_REMOVE: begin
                     // The front element is read here; the walk starts next cycle.
                     if (count_ff == '0) begin
                        status_in = STATUS_EMPTY;
                     end
                  end
                  MODE_CLEAR: begin
                     count_in = '0;
                     head_in  = '0;
                  end
                  default: begin
                  end
               endcase
               if (req_data.mode == MODE_REMOVE && count_ff != '0) begin
                  state_in = ST_SCAN;
               end else if (count_in == '0) begin
                  head_in  = '0;
                  state_in = ST_FINISH;
               end else begin
                  state_in = ST_RD_FRONT;
               end
            end
         end
         ST_SCAN: begin
            // The read data holds element idx; the next element is fetched meanwhile.
            ram_raddr = slot_of(head_ff, idx_next);
            if (key_match) begin
               state_in = ST_SHIFT;
            end else if (idx_next == count_s) begin
               status_in = STATUS_NOT_FOUND;
               state_in  = ST_RD_FRONT;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_SHIFT: begin
            // The read data holds element idx+1, which moves one place forward.
            if (idx_next < count_s) begin
               ram_we    = 1'b1;
               ram_waddr = slot_of(head_ff, SW'(idx_ff));
               ram_wdata = ram_rdata;
               ram_raddr = slot_of(head_ff, idx_ahead);
               idx_in    = idx_ff + 1'b1;
            end else begin
               count_in = count_ff - 1'b1;
               if (count_in == '0) begin
                  head_in  = '0;
                  state_in = ST_FINISH;
               end else begin
                  state_in = ST_RD_FRONT;
               end
            end
         end
         ST_RD_FRONT: begin
            ram_raddr = head_ff;
            state_in  = ST_RD_BACK;
         end
         ST_RD_BACK: begin
            front_in  = ram_rdata;
            ram_raddr = slot_of(head_ff, count_s - SW'(1));
            state_in  = ST_FINISH;
         end
         ST_FINISH: begin
            rsp_valid_in  = 1'b1;
            rsp_in.status = status_ff;
            rsp_in.count  = 7'(count_ff);
            if (count_ff == '0) begin
               rsp_in.front_value = '0;
               rsp_in.back_value  = '0;
               rsp_in.is_empty    = 1'b1;
            end else begin
               rsp_in.front_value = 32'(front_ff);
               rsp_in.back_value  = 32'(ram_rdata);
               rsp_in.is_empty    = 1'b0;
            end
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff    <= idx_in;
      key_ff    <= key_in;
      front_ff  <= front_in;
      status_ff <= status_in;
      rsp_ff    <= rsp_in;
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = rsp_valid_ff;
   assign rsp_data   = rsp_ff;

endmodule

// ----- rtl/core/bounded_ordered_list_engine.sv -----
// Top level of the bounded ordered list engine.
// Instantiates the sequencer (bole_ctrl) and the element RAM (bole_ram).
// Depends on bole_pkg.
//
// Usage:
// A request is taken at a rising edge with start high and busy low. It carries
// a mode (push front, push back, pop front, pop back, remove by value, clear)
// and a value. Every request produces exactly one response: rsp_strobe is high
// for one cycle with status, element count, front and back values and an empty
// flag on rsp_data. The receiver cannot hold a response off.
// Between taking a request and showing its response: a push, pop, clear or
// unused mode that leaves the list empty, and a remove from an empty list,
// go straight to the response; the other push, pop and unused cases first
// read the new front and back back from the element RAM. Remove by value
// walks the list one element per cycle and then closes the gap one element
// per cycle, and reads the new front and back unless the removal empties the
// list. busy is low again in the cycle the response is shown, so the next
// request can be taken then.
// Reset empties the list at once; the RAM contents need no clearing.
module bounded_ordered_list_engine #(
   parameter int DEPTH      = bole_pkg::DEPTH_DEF,
   parameter int DATA_WIDTH = bole_pkg::DATA_WIDTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  bole_pkg::req_type req_data,
   output logic              busy,
   output logic              rsp_strobe,
   output bole_pkg::rsp_type rsp_data
);

   import bole_pkg::*;

   localparam int AW = $clog2(DEPTH);

   logic                  ram_we;
   logic [AW-1:0]         ram_waddr;
   logic [DATA_WIDTH-1:0] ram_wdata;
   logic [AW-1:0]         ram_raddr;
   logic [DATA_WIDTH-1:0] ram_rdata;

   bole_ctrl #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_data   (req_data),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .ram_we     (ram_we),
      .ram_waddr  (ram_waddr),
      .ram_wdata  (ram_wdata),
      .ram_raddr  (ram_raddr),
      .ram_rdata  (ram_rdata)
   );

   bole_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

endmodule
